// ===== rtl/rc4_pkg.sv =====
package rc4_pkg;

  localparam int BYTE_W        = 8;
  localparam int PERM_SIZE     = 256;
  localparam int KEY_W         = 64;
  localparam int KEY_BYTES_DEF = 16;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

  // commands from the controller, one per datapath step
  typedef struct packed {
    logic load_in;
    logic fill;
    logic mix_rd_i;
    logic mix_rd_j;
    logic mix_wr_i;
    logic mix_wr_j;
    logic rd_i;
    logic rd_j;
    logic wr_i;
    logic wr_j;
    logic ks;
    logic load_out;
  } rc4_cmd_t;

  typedef struct packed {
    logic cnt_last;
  } rc4_stat_t;

endpackage

// ===== rtl/rc4_ram.sv =====
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rc4_ctrl.sv =====
module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      message_start,
  output logic      out_valid,
  input  logic      out_ready,
  input  rc4_stat_t stat,
  output rc4_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_FILL   = 12'b0000_0000_0010,
    S_MIX_RI = 12'b0000_0000_0100,
    S_MIX_RJ = 12'b0000_0000_1000,
    S_MIX_WI = 12'b0000_0001_0000,
    S_MIX_WJ = 12'b0000_0010_0000,
    S_RD_I   = 12'b0000_0100_0000,
    S_RD_J   = 12'b0000_1000_0000,
    S_WR_I   = 12'b0001_0000_0000,
    S_WR_J   = 12'b0010_0000_0000,
    S_KS     = 12'b0100_0000_0000,
    S_OUT    = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;
  logic   sched_done, sched_done_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next      = state;
    sched_done_next = sched_done;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = (message_start || !sched_done) ? S_FILL : S_RD_I;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (stat.cnt_last) begin
          state_next = S_MIX_RI;
        end
      end
      S_MIX_RI: begin
        cmd.mix_rd_i = 1'b1;
        state_next   = S_MIX_RJ;
      end
      S_MIX_RJ: begin
        cmd.mix_rd_j = 1'b1;
        state_next   = S_MIX_WI;
      end
      S_MIX_WI: begin
        cmd.mix_wr_i = 1'b1;
        state_next   = S_MIX_WJ;
      end
      S_MIX_WJ: begin
        cmd.mix_wr_j = 1'b1;
        if (stat.cnt_last) begin
          sched_done_next = 1'b1;
          state_next      = S_RD_I;
        end else begin
          state_next = S_MIX_RI;
        end
      end
      S_RD_I: begin
        cmd.rd_i   = 1'b1;
        state_next = S_RD_J;
      end
      S_RD_J: begin
        cmd.rd_j   = 1'b1;
        state_next = S_WR_I;
      end
      S_WR_I: begin
        cmd.wr_i   = 1'b1;
        state_next = S_WR_J;
      end
      S_WR_J: begin
        cmd.wr_j   = 1'b1;
        state_next = S_KS;
      end
      S_KS: begin
        cmd.ks     = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sched_done <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      sched_done <= sched_done_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rc4_dp.sv =====
module rc4_dp
  import rc4_pkg::*;
#(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic                 message_end,
  input  rc4_cmd_t             cmd,
  output rc4_stat_t            stat,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_last
);

  localparam int AW     = $clog2(PERM_SIZE);
  localparam int KPOS_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [KPOS_W-1:0] KPOS_LAST = KPOS_W'(KEY_BYTES - 1);

  logic [KEY_W-1:0]   key_low, key_high;
  logic [2*KEY_W-1:0] key_all;
  logic [BYTE_W-1:0]  key_byte;

  logic [AW-1:0]     cnt;
  logic [KPOS_W-1:0] kpos;
  logic [AW-1:0]     idx_i, idx_j;
  logic [BYTE_W-1:0] si, sj, ks;
  logic              kfwd;
  logic [BYTE_W-1:0] data_q;
  logic              last_q;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [BYTE_W-1:0] wdata, rdata;

  logic [AW-1:0] i_inc, j_byte, j_mix, k_addr;

  assign key_all  = {key_high, key_low};
  assign key_byte = key_all[int'(kpos)*BYTE_W +: BYTE_W];

  assign i_inc  = idx_i + 1'b1;
  assign j_byte = idx_j + rdata;
  assign j_mix  = idx_j + rdata + key_byte;
  assign k_addr = si + sj;

  assign stat.cnt_last = (cnt == {AW{1'b1}});

  // one memory port each way, steered by the current step
  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = cnt;
    raddr = cnt;
    if (cmd.fill) begin
      we = 1'b1;
    end
    if (cmd.mix_rd_i) begin
      raddr = cnt;
    end
    if (cmd.mix_rd_j) begin
      raddr = j_mix;
    end
    if (cmd.mix_wr_i) begin
      we    = 1'b1;
      wdata = rdata;
    end
    if (cmd.mix_wr_j) begin
      we    = 1'b1;
      waddr = idx_j;
      wdata = si;
    end
    if (cmd.rd_i) begin
      raddr = i_inc;
    end
    if (cmd.rd_j) begin
      raddr = j_byte;
    end
    if (cmd.wr_i) begin
      we    = 1'b1;
      waddr = idx_i;
      wdata = rdata;
    end
    if (cmd.wr_j) begin
      we    = 1'b1;
      waddr = idx_j;
      wdata = si;
      raddr = k_addr;
    end
  end

  rc4_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(PERM_SIZE)
  ) u_perm (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      cnt      <= '0;
      kpos     <= '0;
      idx_i    <= '0;
      idx_j    <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_KEY_LOW:  key_low  <= cfg_data;
          REG_KEY_HIGH: key_high <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.fill) begin
        cnt <= cnt + 1'b1;
        if (stat.cnt_last) begin
          idx_j <= '0;
          kpos  <= '0;
        end
      end
      if (cmd.mix_rd_j) begin
        idx_j <= j_mix;
      end
      if (cmd.mix_wr_j) begin
        cnt  <= cnt + 1'b1;
        kpos <= (kpos == KPOS_LAST) ? '0 : kpos + 1'b1;
        if (stat.cnt_last) begin
          idx_i <= '0;
          idx_j <= '0;
        end
      end
      if (cmd.rd_i) begin
        idx_i <= i_inc;
      end
      if (cmd.rd_j) begin
        idx_j <= j_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      data_q <= data_byte;
      last_q <= message_end;
    end
    if (cmd.mix_rd_j || cmd.rd_j) begin
      si <= rdata;
    end
    if (cmd.mix_wr_i || cmd.wr_i) begin
      sj <= rdata;
    end
    // keystream read overlaps the write of S[j]: forward it on a hit
    if (cmd.wr_j) begin
      kfwd <= (k_addr == idx_j);
    end
    if (cmd.ks) begin
      ks <= kfwd ? si : rdata;
    end
    if (cmd.load_out) begin
      out_byte <= data_q ^ ks;
      out_last <= last_q;
    end
  end

endmodule

// ===== rtl/rc4_keystream_cipher_core.sv =====
// RC4 stream cipher core: each input word is one data byte, returned XORed with the
// next keystream byte (encrypt and decrypt are the same). Load the key through the
// config port (index 0 = key bytes 0..7, index 1 = key bytes 8..15, byte n at bits
// 8n+7..8n); only the first KEY_BYTES key bytes are used, and a new key takes effect
// at the next message start. The key schedule runs before a word that has
// message_start set and before the first word after reset; it fills the permutation,
// then mixes each entry by reading S[i] and S[j] and writing both back. Each byte then
// takes the steps set by the single read and single write port of the 256-entry
// permutation memory: read S[i], read S[j], write both back, read the keystream byte;
// a new word is not taken until the last one's result is in the output register.
// A finished result waits in the output register while the next word is accepted.
module rc4_keystream_cipher_core
  import rc4_pkg::*;
#(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic                 message_start,
  input  logic                 message_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_last
);

  rc4_cmd_t  cmd;
  rc4_stat_t stat;

  assign cfg_ready = 1'b1;

  rc4_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .message_start(message_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  rc4_dp #(
    .KEY_BYTES(KEY_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .data_byte  (data_byte),
    .message_end(message_end),
    .cmd        (cmd),
    .stat       (stat),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule
